// ----- rtl/stable_min_priority_queue_assert.svh -----
// Assertion macros used by the checker file of the priority queue.
// Depends on nothing; each macro samples on clk and is disabled in reset.
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// Clocked assertion, disabled while rst is high
`define SMPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, but only checked when a result is shown on the output channel
`define SMPQ_ASSERT_OUT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) out_valid |-> (prop)) \
    else $error(msg);

`endif

// ----- rtl/smpq_pkg.sv -----
// Shared constants and types of the stable min-first priority queue.
// No dependencies; used by smpq_cell, the top level and the checker.
package smpq_pkg;

  // Field widths fixed by the interface
  localparam int TAG_W     = 24;
  localparam int PRI_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int HELD_W    = 5;

  // Parameter defaults
  localparam int CAPACITY_DEF      = 16;
  localparam int PRIORITY_BITS_DEF = 16;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert that is really applied (queue not full)
    logic rem;  // remove that is really applied (queue not empty)
  } smpq_ctl_t;

endpackage

// ----- rtl/smpq_cell.sv -----
// One slot of the sorted queue: holds a tag and a priority and trades them
// with its neighbors on insert (shift toward rear) and remove (toward front).
// Depends on smpq_pkg.
module smpq_cell import smpq_pkg::*; #(
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                            clk,
  input  smpq_ctl_t                       ctl,
  input  logic                            occupied,
  input  logic [TAG_W-1:0]                new_tag,
  input  logic signed [PRIORITY_BITS-1:0] new_pri,
  input  logic                            left_after,
  input  logic [TAG_W-1:0]                left_tag,
  input  logic signed [PRIORITY_BITS-1:0] left_pri,
  input  logic [TAG_W-1:0]                right_tag,
  input  logic signed [PRIORITY_BITS-1:0] right_pri,
  output logic [TAG_W-1:0]                tag,
  output logic signed [PRIORITY_BITS-1:0] pri,
  output logic                            after
);

  logic [TAG_W-1:0]                tag_next;
  logic signed [PRIORITY_BITS-1:0] pri_next;

  // New entry goes behind this slot when it holds a lower or equal priority
  assign after = occupied && (pri <= new_pri);

  // Keep, take the new entry, or shift from a neighbor
  always_comb begin
    tag_next = tag;
    pri_next = pri;
    if (ctl.rem) begin
      tag_next = right_tag;
      pri_next = right_pri;
    end else if (ctl.ins && !after) begin
      if (left_after) begin
        tag_next = new_tag;
        pri_next = new_pri;
      end else begin
        tag_next = left_tag;
        pri_next = left_pri;
      end
    end
  end

  // Slot storage, no reset: only slots below the fill count are read
  always_ff @(posedge clk) begin
    if (ctl.ins || ctl.rem) begin
      tag <= tag_next;
      pri <= pri_next;
    end
  end

endmodule

// ----- rtl/stable_min_priority_queue.sv -----
// Stable min-first priority queue: top level, a row of smpq_cell slots.
// Depends on smpq_pkg and smpq_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, tag, priority_req.
//   operation OP_INSERT places the entry behind every held entry of lower or
//   equal priority; OP_REMOVE takes the front (smallest) entry.
//   Output channel (out_valid/out_ready) returns one result per operation:
//   status, removed entry, head and tail, entries_held and is_empty.
// Output: the result is registered, valid in the cycle after the input
//   transfer. Throughput: one operation per cycle unless the output stalls;
//   every cell compares against the new priority and shifts in the same cycle.
// Stall: in_ready follows the output register; while a result waits for
//   out_ready, no new operation is taken, and the held result stays stable.
// Reset: rst clears the fill count and the output valid flag; slot contents
//   are not cleared and need no clearing pass.
// Full insert is dropped (overflow); empty remove changes nothing (underflow).
module stable_min_priority_queue import smpq_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [TAG_W-1:0]        tag,
  input  logic signed [PRI_W-1:0] priority_req,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [TAG_W-1:0]        taken_tag,
  output logic signed [PRI_W-1:0] taken_priority,
  output logic [TAG_W-1:0]        head_tag,
  output logic signed [PRI_W-1:0] head_priority,
  output logic [TAG_W-1:0]        tail_tag,
  output logic signed [PRI_W-1:0] tail_priority,
  output logic [HELD_W-1:0]       entries_held,
  output logic                    is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PB    = PRIORITY_BITS;

  logic [CNT_W-1:0] count, count_next;
  logic             take, full, empty;
  smpq_ctl_t        ctl;

  logic [PB+PRI_W-1:0]  raw_ext;
  logic signed [PB-1:0] new_pri;

  logic [TAG_W-1:0]     cell_tag [CAPACITY];
  logic signed [PB-1:0] cell_pri [CAPACITY];
  logic [CAPACITY-1:0]  occ, after;
  logic                 rear_new;

  logic [TAG_W-1:0]     rear_tag, rear_tag_next;
  logic signed [PB-1:0] rear_pri, rear_pri_next;

  logic [STATUS_W-1:0]  status_n;
  logic [TAG_W-1:0]     taken_tag_n, head_tag_n, tail_tag_n;
  logic signed [PB-1:0] taken_pri_n, head_pri_n, tail_pri_n;
  logic [PB+PRI_W-1:0]  taken_ext, head_ext, tail_ext;
  logic [CNT_W+HELD_W-1:0] count_ext;

  // Handshake and applied command
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign ctl.ins  = take && (operation == OP_INSERT) && !full;
  assign ctl.rem  = take && (operation == OP_REMOVE) && !empty;

  // Incoming priority read as PRIORITY_BITS-bit two's complement
  assign raw_ext = (PB + PRI_W)'(unsigned'(priority_req));
  assign new_pri = signed'(raw_ext[PB-1:0]);

  // Row of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 l_after;
    logic [TAG_W-1:0]     l_tag, r_tag;
    logic signed [PB-1:0] l_pri, r_pri;

    assign occ[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign l_after = 1'b1;
      assign l_tag   = tag;
      assign l_pri   = new_pri;
    end else begin : g_mid
      assign l_after = after[i-1];
      assign l_tag   = cell_tag[i-1];
      assign l_pri   = cell_pri[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_tag = cell_tag[i];
      assign r_pri = cell_pri[i];
    end else begin : g_inner
      assign r_tag = cell_tag[i+1];
      assign r_pri = cell_pri[i+1];
    end

    smpq_cell #(.PRIORITY_BITS(PB)) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .new_tag    (tag),
      .new_pri    (new_pri),
      .left_after (l_after),
      .left_tag   (l_tag),
      .left_pri   (l_pri),
      .right_tag  (r_tag),
      .right_pri  (r_pri),
      .tag        (cell_tag[i]),
      .pri        (cell_pri[i]),
      .after      (after[i])
    );
  end

  // New entry becomes the rear when every held entry goes ahead of it
  assign rear_new = &(after | ~occ);

  // Fill count and rear copy
  always_comb begin
    count_next    = count;
    rear_tag_next = rear_tag;
    rear_pri_next = rear_pri;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
      if (rear_new) begin
        rear_tag_next = tag;
        rear_pri_next = new_pri;
      end
    end else if (ctl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rear_tag <= rear_tag_next;
    rear_pri <= rear_pri_next;
  end

  // Result of the operation, seen after it is applied
  always_comb begin
    status_n    = ST_OK;
    taken_tag_n = '0;
    taken_pri_n = '0;
    head_tag_n  = cell_tag[0];
    head_pri_n  = cell_pri[0];
    tail_tag_n  = rear_tag_next;
    tail_pri_n  = rear_pri_next;
    if (take && (operation == OP_INSERT) && full) begin
      status_n = ST_OVERFLOW;
    end else if (take && (operation == OP_REMOVE) && empty) begin
      status_n = ST_UNDERFLOW;
    end
    if (ctl.rem) begin
      taken_tag_n = cell_tag[0];
      taken_pri_n = cell_pri[0];
      head_tag_n  = cell_tag[1];
      head_pri_n  = cell_pri[1];
    end else if (ctl.ins && !after[0]) begin
      head_tag_n = tag;
      head_pri_n = new_pri;
    end
    if (count_next == '0) begin
      head_tag_n = '0;
      head_pri_n = '0;
      tail_tag_n = '0;
      tail_pri_n = '0;
    end
  end

  // Sign-extend stored priorities, then keep the low field bits
  assign taken_ext = (PB + PRI_W)'(taken_pri_n);
  assign head_ext  = (PB + PRI_W)'(head_pri_n);
  assign tail_ext  = (PB + PRI_W)'(tail_pri_n);
  assign count_ext = (CNT_W + HELD_W)'(count_next);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status         <= status_n;
      taken_tag      <= taken_tag_n;
      taken_priority <= signed'(taken_ext[PRI_W-1:0]);
      head_tag       <= head_tag_n;
      head_priority  <= signed'(head_ext[PRI_W-1:0]);
      tail_tag       <= tail_tag_n;
      tail_priority  <= signed'(tail_ext[PRI_W-1:0]);
      entries_held   <= count_ext[HELD_W-1:0];
      is_empty       <= (count_next == '0);
    end
  end

endmodule

// ----- rtl/smpq_checker.sv -----
// Port-level checker for the priority queue, bound to the top level.
// Depends on smpq_pkg and stable_min_priority_queue_assert.svh.
`include "stable_min_priority_queue_assert.svh"

module smpq_checker import smpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [STATUS_W-1:0]     status,
  input logic [TAG_W-1:0]        taken_tag,
  input logic signed [PRI_W-1:0] taken_priority,
  input logic [HELD_W-1:0]       entries_held,
  input logic                    is_empty
);

  localparam logic [HELD_W+8:0] CAP_W = (HELD_W + 9)'(CAPACITY);

  // A stalled result is held until its transfer
  `SMPQ_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entries_held), "result changed while stalled")

  // Empty flag agrees with the count
  `SMPQ_ASSERT_OUT(a_empty_flag, is_empty == (entries_held == '0), "is_empty disagrees with entries_held")

  // Underflow leaves an empty queue and reports no taken entry
  `SMPQ_ASSERT_OUT(a_underflow, status != ST_UNDERFLOW || (is_empty && taken_tag == '0 && taken_priority == '0), "bad underflow result")

  // Overflow only reported with a full queue
  `SMPQ_ASSERT_OUT(a_overflow, status != ST_OVERFLOW || (HELD_W + 9)'(entries_held) == CAP_W || CAPACITY > 31, "overflow below capacity")

endmodule

bind stable_min_priority_queue smpq_checker #(.CAPACITY(CAPACITY)) u_smpq_checker (.*);

// ----- test/smpq_checker.sv -----
// Scoreboard for the stable min-first priority queue: watches both channels.
// Keeps a sorted-slot model of the queue and compares every result field.
// Depends on smpq_pkg.
`timescale 1ns / 1ps

module smpq_scoreboard import smpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    operation,
  input  logic [TAG_W-1:0]        tag,
  input  logic signed [PRI_W-1:0] priority_req,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [STATUS_W-1:0]     status,
  input  logic [TAG_W-1:0]        taken_tag,
  input  logic signed [PRI_W-1:0] taken_priority,
  input  logic [TAG_W-1:0]        head_tag,
  input  logic signed [PRI_W-1:0] head_priority,
  input  logic [TAG_W-1:0]        tail_tag,
  input  logic signed [PRI_W-1:0] tail_priority,
  input  logic [HELD_W-1:0]       entries_held,
  input  logic                    is_empty,
  output int                      fail_count,
  output int                      results_owed
);

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [TAG_W-1:0]        taken_tag;
    logic signed [PRI_W-1:0] taken_pri;
    logic [TAG_W-1:0]        head_tag;
    logic signed [PRI_W-1:0] head_pri;
    logic [TAG_W-1:0]        tail_tag;
    logic signed [PRI_W-1:0] tail_pri;
    logic [HELD_W-1:0]       held;
    logic                    empty;
  } queue_result_t;

  // Model of the slot row, ascending priority, front at index 0
  logic signed [PRI_W-1:0] model_pri [CAPACITY];
  logic [TAG_W-1:0]        model_tag [CAPACITY];
  int                      model_count;

  queue_result_t expected_results [$];

  // Apply one operation to the model and build the result it answers with
  task automatic apply_queue_op(input logic op, input logic [TAG_W-1:0] t,
                                input logic signed [PRI_W-1:0] p,
                                output queue_result_t r);
    int pos;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (model_count >= CAPACITY) begin
        r.status = ST_OVERFLOW;
      end else begin
        // new entry goes behind every entry of lower or equal priority
        pos = 0;
        while (pos < model_count && model_pri[pos] <= p) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_pri[i] = model_pri[i-1];
          model_tag[i] = model_tag[i-1];
        end
        model_pri[pos] = p;
        model_tag[pos] = t;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.taken_tag = model_tag[0];
        r.taken_pri = model_pri[0];
        for (int i = 1; i < model_count; i++) begin
          model_pri[i-1] = model_pri[i];
          model_tag[i-1] = model_tag[i];
        end
        model_count--;
      end
    end
    r.held  = model_count[HELD_W-1:0];
    r.empty = (model_count == 0);
    if (model_count != 0) begin
      r.head_tag = model_tag[0];
      r.head_pri = model_pri[0];
      r.tail_tag = model_tag[model_count-1];
      r.tail_pri = model_pri[model_count-1];
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Output transfer is matched first: it belongs to an earlier input transfer
  always @(posedge clk) begin
    queue_result_t want;
    queue_result_t got;
    if (rst) begin
      model_count = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, status %0h", $time, status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status);
          check_field("taken_tag", want.taken_tag, taken_tag);
          check_field("taken_priority", want.taken_pri, taken_priority);
          check_field("head_tag", want.head_tag, head_tag);
          check_field("head_priority", want.head_pri, head_priority);
          check_field("tail_tag", want.tail_tag, tail_tag);
          check_field("tail_priority", want.tail_pri, tail_priority);
          check_field("entries_held", want.held, entries_held);
          check_field("is_empty", want.empty, is_empty);
        end
      end
      if (in_valid && in_ready) begin
        apply_queue_op(operation, tag, priority_req, got);
        expected_results.push_back(got);
      end
    end
    results_owed = expected_results.size();
  end

endmodule

// ----- test/tb_stable_min_priority_queue.sv -----
// Testbench top for the stable min-first priority queue: clock, reset, stimulus.
// Depends on smpq_pkg, the block and smpq_scoreboard; the scoreboard does the compare.
`timescale 1ns / 1ps

module tb_stable_min_priority_queue import smpq_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 200;  // result count at which the receiver holds off
  localparam int HOLD_CYCLES = 150;

  typedef enum int {PRI_SPREAD, PRI_CLUSTER, PRI_EXTREME} pri_mix_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    operation;
  logic [TAG_W-1:0]        tag;
  logic signed [PRI_W-1:0] priority_req;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     status;
  logic [TAG_W-1:0]        taken_tag;
  logic signed [PRI_W-1:0] taken_priority;
  logic [TAG_W-1:0]        head_tag;
  logic signed [PRI_W-1:0] head_priority;
  logic [TAG_W-1:0]        tail_tag;
  logic signed [PRI_W-1:0] tail_priority;
  logic [HELD_W-1:0]       entries_held;
  logic                    is_empty;

  int fail_count;
  int results_owed;
  int cycle_count;
  bit calm;  // no idling on either side while set

  stable_min_priority_queue dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .tag(tag), .priority_req(priority_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .taken_tag(taken_tag), .taken_priority(taken_priority),
    .head_tag(head_tag), .head_priority(head_priority),
    .tail_tag(tail_tag), .tail_priority(tail_priority),
    .entries_held(entries_held), .is_empty(is_empty)
  );

  smpq_scoreboard u_scoreboard (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .tag(tag), .priority_req(priority_req),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .taken_tag(taken_tag), .taken_priority(taken_priority),
    .head_tag(head_tag), .head_priority(head_priority),
    .tail_tag(tail_tag), .tail_priority(tail_priority),
    .entries_held(entries_held), .is_empty(is_empty),
    .fail_count(fail_count), .results_owed(results_owed)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offer one operation; returns at the edge of its transfer
  task automatic send_op(input logic op, input logic [TAG_W-1:0] t,
                         input logic signed [PRI_W-1:0] p);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    tag          <= t;
    priority_req <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [PRI_W-1:0] draw_priority(input pri_mix_t mix);
    int v;
    case (mix)
      PRI_CLUSTER: begin
        v = int'($urandom_range(0, 4)) - 2;
        return v[PRI_W-1:0];
      end
      PRI_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return PRI_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic run_phase(input int count, input int insert_pct, input pri_mix_t mix);
    logic op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
      send_op(op, TAG_W'($urandom_range(0, 24'hFFFFFF)), draw_priority(mix));
    end
  endtask

  // Receiver: random stalls per result, one long hold-off to back up the input
  initial begin
    int stall;
    int taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    out_ready    = 1'b0;
    operation    = OP_INSERT;
    tag          = '0;
    priority_req = '0;
    calm         = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: underflow, extremes, ties, fill to full, overflow, drain a few
    send_op(OP_REMOVE, 24'hFFFFFF, 16'sh7FFF);
    send_op(OP_INSERT, 24'hFFFFFF, 16'sh7FFF);
    send_op(OP_INSERT, 24'h000000, 16'sh8000);
    send_op(OP_INSERT, 24'h414243, 16'sh0000);
    send_op(OP_INSERT, 24'h444546, 16'sh0000);
    send_op(OP_INSERT, 24'h474849, 16'sh0000);
    send_op(OP_INSERT, 24'h800001, 16'shFFFF);
    send_op(OP_INSERT, 24'h7FFFFE, 16'sh0001);
    send_op(OP_INSERT, 24'h555555, 16'sh8000);
    send_op(OP_INSERT, 24'hAAAAAA, 16'sh7FFF);
    for (int i = 0; i < 7; i++)
      send_op(OP_INSERT, TAG_W'(24'h100000 + i), 16'(i * 5000 - 12000));
    send_op(OP_INSERT, 24'h123456, 16'sh0000);  // full: dropped
    for (int i = 0; i < 5; i++)
      send_op(OP_REMOVE, '0, '0);

    // Random phases with different mixes of inserts and priority spreads
    run_phase(120, 70, PRI_SPREAD);
    run_phase(100, 30, PRI_CLUSTER);
    calm = 1'b1;
    run_phase(100, 55, PRI_CLUSTER);
    calm = 1'b0;
    run_phase(150, 50, PRI_EXTREME);
    run_phase(130, 60, PRI_SPREAD);
    calm = 1'b1;
    run_phase(80, 50, PRI_SPREAD);
    calm = 1'b0;
    run_phase(70, 25, PRI_CLUSTER);
    in_valid <= 1'b0;

    // Drain, then wait quietly for stray results
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (5) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
